### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// implication checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// same check, also active during reset
`define ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk_s, rst_s, prop, msg)
`define ASSERT_ALWAYS(lbl, clk_s, prop, msg)

`endif

`endif

### design/dasd_pkg.sv
// ----------------------------------------------------------------------------
// dasd_pkg
// Types, operation codes and calendar helpers for the date add/subtract block.
// ----------------------------------------------------------------------------
package dasd_pkg;

    localparam int InWidth  = 56;
    localparam int OutWidth = 64;

    // datapath operations
    localparam logic [3:0] OP_NONE       = 4'd0;
    localparam logic [3:0] OP_LOAD       = 4'd1;
    localparam logic [3:0] OP_MOD        = 4'd2;
    localparam logic [3:0] OP_CHECK      = 4'd3;
    localparam logic [3:0] OP_ADD_YEAR   = 4'd4;
    localparam logic [3:0] OP_SPLIT_INIT = 4'd5;
    localparam logic [3:0] OP_SPLIT_STEP = 4'd6;
    localparam logic [3:0] OP_SUB_INIT   = 4'd7;
    localparam logic [3:0] OP_SUB_YEAR   = 4'd8;
    localparam logic [3:0] OP_RESULT     = 4'd9;

    localparam logic [13:0] YEAR_CYCLE = 14'd400;
    localparam logic [2:0]  MOD_STEPS_LAST = 3'd5;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] shift;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic add_more;
        logic split_more;
        logic sub_more;
    } status_t;

    // leap test from the year's residue modulo 400
    function automatic logic leap_of(input logic [13:0] r);
        return (r[1:0] == 2'd0) && (r != 14'd100) && (r != 14'd200) && (r != 14'd300);
    endfunction

    function automatic logic [8:0] year_len(input logic leap);
        return leap ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // days before the first of month m in a common year
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

### design/dasd_datapath.sv
// ----------------------------------------------------------------------------
// dasd_datapath
// Date registers, year residue, ordinal stepping and the result register.
// ----------------------------------------------------------------------------
module dasd_datapath (
    input  logic                          clk,
    input  logic [dasd_pkg::InWidth-1:0]  in_data,
    input  dasd_pkg::cmd_t                cmd,
    output dasd_pkg::status_t             status,
    output logic [dasd_pkg::OutWidth-1:0] out_data
);

    logic [4:0]         day_reg,   day_next;
    logic [3:0]         month_reg, month_next;
    logic [15:0]        sub_reg,   sub_next;
    logic [15:0]        add_reg,   add_next;
    logic [13:0]        res_reg,   res_next;    // year modulo 400
    logic signed [15:0] year_reg,  year_next;
    logic signed [17:0] ord_reg,   ord_next;    // ordinal within year_reg
    logic [8:0]         rem_reg,   rem_next;    // ordinal left for month split
    logic [3:0]         mon_reg,   mon_next;
    logic               valid_reg, valid_next;
    logic               leap0_reg, leap0_next;
    logic [8:0]         doy_reg,   doy_next;
    logic [4:0]         sday_reg,  sday_next;
    logic [3:0]         smon_reg,  smon_next;
    logic [13:0]        syear_reg, syear_next;
    logic [dasd_pkg::OutWidth-1:0] out_reg, out_next;

    logic        leap;
    logic [13:0] res_dec;
    logic        leap_prev;
    logic [13:0] mod_div;
    logic [4:0]  cur_mlen;
    logic [4:0]  in_mlen;
    logic        in_ok;

    assign leap      = dasd_pkg::leap_of(res_reg);
    assign res_dec   = (res_reg == 14'd0) ? (dasd_pkg::YEAR_CYCLE - 14'd1) : (res_reg - 14'd1);
    assign leap_prev = dasd_pkg::leap_of(res_dec);
    assign mod_div   = dasd_pkg::YEAR_CYCLE << cmd.shift;
    assign cur_mlen  = dasd_pkg::month_len(mon_reg, leap);
    assign in_mlen   = dasd_pkg::month_len(month_reg, leap);
    assign in_ok     = (month_reg >= 4'd1) && (month_reg <= 4'd12) &&
                       (day_reg != 5'd0) && (day_reg <= in_mlen);

    assign status.valid      = valid_reg;
    assign status.add_more   = ord_reg > $signed({9'd0, dasd_pkg::year_len(leap)});
    assign status.split_more = (mon_reg < 4'd12) && (rem_reg > {4'd0, cur_mlen});
    assign status.sub_more   = ord_reg[17] || (ord_reg == 18'sd0);

    assign out_data = out_reg;

    always_comb
    begin
        day_next   = day_reg;
        month_next = month_reg;
        add_next   = add_reg;
        sub_next   = sub_reg;
        res_next   = res_reg;
        year_next  = year_reg;
        ord_next   = ord_reg;
        rem_next   = rem_reg;
        mon_next   = mon_reg;
        valid_next = valid_reg;
        leap0_next = leap0_reg;
        doy_next   = doy_reg;
        sday_next  = sday_reg;
        smon_next  = smon_reg;
        syear_next = syear_reg;
        out_next   = out_reg;
        case (cmd.op)
            dasd_pkg::OP_LOAD:
            begin
                day_next   = in_data[4:0];
                month_next = in_data[8:5];
                res_next   = in_data[22:9];
                year_next  = $signed({2'b00, in_data[22:9]});
                add_next   = in_data[38:23];
                sub_next   = in_data[54:39];
            end
            dasd_pkg::OP_MOD:
            begin
                // restoring reduction by 400 shifted
                if (res_reg >= mod_div)
                begin
                    res_next = res_reg - mod_div;
                end
            end
            dasd_pkg::OP_CHECK:
            begin
                valid_next = in_ok;
                leap0_next = leap;
                doy_next   = dasd_pkg::days_before(month_reg) + {4'd0, day_reg} +
                             {8'd0, leap && (month_reg > 4'd2)};
                ord_next   = $signed({9'd0, doy_next} + {2'd0, add_reg});
            end
            dasd_pkg::OP_ADD_YEAR:
            begin
                ord_next  = ord_reg - $signed({9'd0, dasd_pkg::year_len(leap)});
                year_next = year_reg + 16'sd1;
                res_next  = (res_reg == dasd_pkg::YEAR_CYCLE - 14'd1) ? 14'd0 : res_reg + 14'd1;
            end
            dasd_pkg::OP_SPLIT_INIT:
            begin
                rem_next = ord_reg[8:0];
                mon_next = 4'd1;
            end
            dasd_pkg::OP_SPLIT_STEP:
            begin
                rem_next = rem_reg - {4'd0, cur_mlen};
                mon_next = mon_reg + 4'd1;
            end
            dasd_pkg::OP_SUB_INIT:
            begin
                sday_next  = rem_reg[4:0];
                smon_next  = mon_reg;
                syear_next = year_reg[13:0];
                ord_next   = ord_reg - $signed({2'd0, sub_reg});
            end
            dasd_pkg::OP_SUB_YEAR:
            begin
                ord_next  = ord_reg + $signed({9'd0, dasd_pkg::year_len(leap_prev)});
                year_next = year_reg - 16'sd1;
                res_next  = res_dec;
            end
            dasd_pkg::OP_RESULT:
            begin
                if (valid_reg)
                begin
                    out_next = {6'd0, year_reg[14:0], mon_reg, rem_reg[4:0],
                                syear_reg, smon_reg, sday_reg, doy_reg, leap0_reg, 1'b1};
                end
                else
                begin
                    out_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        day_reg   <= day_next;
        month_reg <= month_next;
        add_reg   <= add_next;
        sub_reg   <= sub_next;
        res_reg   <= res_next;
        year_reg  <= year_next;
        ord_reg   <= ord_next;
        rem_reg   <= rem_next;
        mon_reg   <= mon_next;
        valid_reg <= valid_next;
        leap0_reg <= leap0_next;
        doy_reg   <= doy_next;
        sday_reg  <= sday_next;
        smon_reg  <= smon_next;
        syear_reg <= syear_next;
        out_reg   <= out_next;
    end

endmodule

### design/dasd_ctrl.sv
// ----------------------------------------------------------------------------
// dasd_ctrl
// Sequencer for the date block: handshakes and datapath operations.
// ----------------------------------------------------------------------------
module dasd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  dasd_pkg::status_t status,
    output dasd_pkg::cmd_t    cmd
);

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_MOD        = 3'd1;
    localparam logic [2:0] S_CHECK      = 3'd2;
    localparam logic [2:0] S_ADD        = 3'd3;
    localparam logic [2:0] S_SPLIT_SUM  = 3'd4;
    localparam logic [2:0] S_SUB        = 3'd5;
    localparam logic [2:0] S_SPLIT_DIFF = 3'd6;
    localparam logic [2:0] S_FINISH     = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [2:0] shift_reg, shift_next;
    logic       oval_reg,  oval_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = oval_reg;

    always_comb
    begin
        state_next = state_reg;
        shift_next = shift_reg;
        oval_next  = oval_reg;
        cmd.op     = dasd_pkg::OP_NONE;
        cmd.shift  = shift_reg;
        if (oval_reg && out_ready)
        begin
            oval_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = dasd_pkg::OP_LOAD;
                    shift_next = dasd_pkg::MOD_STEPS_LAST;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                cmd.op = dasd_pkg::OP_MOD;
                if (shift_reg == 3'd0)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    shift_next = shift_reg - 3'd1;
                end
            end
            S_CHECK:
            begin
                cmd.op     = dasd_pkg::OP_CHECK;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if (!status.valid)
                begin
                    state_next = S_FINISH;
                end
                else if (status.add_more)
                begin
                    cmd.op = dasd_pkg::OP_ADD_YEAR;
                end
                else
                begin
                    cmd.op     = dasd_pkg::OP_SPLIT_INIT;
                    state_next = S_SPLIT_SUM;
                end
            end
            S_SPLIT_SUM:
            begin
                if (status.split_more)
                begin
                    cmd.op = dasd_pkg::OP_SPLIT_STEP;
                end
                else
                begin
                    cmd.op     = dasd_pkg::OP_SUB_INIT;
                    state_next = S_SUB;
                end
            end
            S_SUB:
            begin
                if (status.sub_more)
                begin
                    cmd.op = dasd_pkg::OP_SUB_YEAR;
                end
                else
                begin
                    cmd.op     = dasd_pkg::OP_SPLIT_INIT;
                    state_next = S_SPLIT_DIFF;
                end
            end
            S_SPLIT_DIFF:
            begin
                if (status.split_more)
                begin
                    cmd.op = dasd_pkg::OP_SPLIT_STEP;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // load the result once the output register is free
                if (!oval_reg || out_ready)
                begin
                    cmd.op     = dasd_pkg::OP_RESULT;
                    oval_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            shift_reg <= 3'd0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            shift_reg <= shift_next;
            oval_reg  <= oval_next;
        end
    end

endmodule

### design/date_add_subtract_days_top.sv
// ----------------------------------------------------------------------------
// date_add_subtract_days_top
// Gregorian date check, day-of-year, add days then subtract days.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         start date, days to add, days to subtract
// m_axis    out        validity, leap flag, day of year, sum date, diff date
//
// One item at a time: the result follows the input transfer after the year
// residue reduction and the date check, plus one step per year crossed by the
// addition and by the subtraction, plus one per month stepped in each of the
// two date splits. The next input transfer can follow in the cycle after the
// result is loaded. A finished result waits in the output register while the
// next item is accepted. Reset clears the sequencer and the output valid flag
// only.
module date_add_subtract_days_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // day_in[4:0], month_in[8:5], year_in[22:9], add_days[38:23],
    // sub_days[54:39], zero fill[55]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // date_valid[0], is_leap[1], day_of_year[10:2], sum_day[15:11],
    // sum_month[19:16], sum_year[33:20], diff_day[38:34], diff_month[42:39],
    // diff_year[57:43], zero fill[63:58]
    output logic [63:0] m_axis_tdata
);

    dasd_pkg::cmd_t    cmd;
    dasd_pkg::status_t status;

    dasd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    dasd_datapath u_datapath (
        .clk      (clk),
        .in_data  (s_axis_tdata),
        .cmd      (cmd),
        .status   (status),
        .out_data (m_axis_tdata)
    );

`include "assert_macros.svh"

    // the block is busy after taking an item
    `ASSERT_CLK(a_busy_after_in, clk, rst_n, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "input accepted while busy")
    // an invalid date gives an all-zero result
    `ASSERT_CLK(a_invalid_zero, clk, rst_n, (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[63:1] == 63'd0), "invalid date with nonzero fields")
    // a valid date gives a real day of year and sum month
    `ASSERT_CLK(a_valid_ranges, clk, rst_n, (m_axis_tvalid && m_axis_tdata[0]) |-> ((m_axis_tdata[10:2] != 9'd0) && (m_axis_tdata[19:16] != 4'd0) && (m_axis_tdata[19:16] <= 4'd12)), "result fields out of range")

endmodule
